// File: rtl/sgr_parameter_style_decoder_core_defines.svh
// Assertion macros for the SGR style decoder.
// Used by the core top level; no other dependencies.
`ifndef SGR_PARAMETER_STYLE_DECODER_CORE_DEFINES_SVH
`define SGR_PARAMETER_STYLE_DECODER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SGRD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SGRD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/sgrd_pkg.sv
// Types and constants for the SGR style decoder.
// No dependencies; used by the interfaces, decoder and top level.
package sgrd_pkg;

  localparam int unsigned ParamW = 16;
  localparam int unsigned FlagsW = 12;
  localparam int unsigned ColourW = 9;

  localparam int unsigned FL_BOLD      = 0;
  localparam int unsigned FL_ITALIC    = 1;
  localparam int unsigned FL_UNDERLINE = 2;
  localparam int unsigned FL_BLINK     = 3;
  localparam int unsigned FL_REVERSE   = 4;
  localparam int unsigned FL_INVISIBLE = 5;
  localparam int unsigned FL_CROSSED   = 6;
  localparam int unsigned FL_DOUBLE_UL = 7;
  localparam int unsigned FL_FG_INDEX  = 8;
  localparam int unsigned FL_BG_INDEX  = 9;
  localparam int unsigned FL_FG_RGB    = 10;
  localparam int unsigned FL_BG_RGB    = 11;

  localparam int unsigned SIDE_FG = 0;
  localparam int unsigned SIDE_BG = 1;

  localparam logic [ParamW-1:0] SGR_RESET       = 16'd0;
  localparam logic [ParamW-1:0] SGR_BOLD        = 16'd1;
  localparam logic [ParamW-1:0] SGR_FAINT       = 16'd2;
  localparam logic [ParamW-1:0] SGR_ITALIC      = 16'd3;
  localparam logic [ParamW-1:0] SGR_UNDERLINE   = 16'd4;
  localparam logic [ParamW-1:0] SGR_BLINK_SLOW  = 16'd5;
  localparam logic [ParamW-1:0] SGR_BLINK_FAST  = 16'd6;
  localparam logic [ParamW-1:0] SGR_REVERSE     = 16'd7;
  localparam logic [ParamW-1:0] SGR_INVISIBLE   = 16'd8;
  localparam logic [ParamW-1:0] SGR_CROSSED     = 16'd9;
  localparam logic [ParamW-1:0] SGR_ALT_FONT    = 16'd17;
  localparam logic [ParamW-1:0] SGR_DOUBLE_UL   = 16'd21;
  localparam logic [ParamW-1:0] SGR_NO_ITALIC   = 16'd23;
  localparam logic [ParamW-1:0] SGR_NO_UL       = 16'd24;
  localparam logic [ParamW-1:0] SGR_NO_REVERSE  = 16'd27;
  localparam logic [ParamW-1:0] SGR_NO_INVIS    = 16'd28;
  localparam logic [ParamW-1:0] SGR_NO_CROSSED  = 16'd29;
  localparam logic [ParamW-1:0] SGR_FG_BLACK    = 16'd30;
  localparam logic [ParamW-1:0] SGR_FG_LO_FIRST = 16'd31;
  localparam logic [ParamW-1:0] SGR_FG_LO_LAST  = 16'd37;
  localparam logic [ParamW-1:0] SGR_FG_EXT      = 16'd38;
  localparam logic [ParamW-1:0] SGR_FG_DEFAULT  = 16'd39;
  localparam logic [ParamW-1:0] SGR_BG_BLACK    = 16'd40;
  localparam logic [ParamW-1:0] SGR_BG_LO_FIRST = 16'd41;
  localparam logic [ParamW-1:0] SGR_BG_LO_LAST  = 16'd47;
  localparam logic [ParamW-1:0] SGR_BG_EXT      = 16'd48;
  localparam logic [ParamW-1:0] SGR_BG_DEFAULT  = 16'd49;
  localparam logic [ParamW-1:0] SGR_FG_GREY     = 16'd90;
  localparam logic [ParamW-1:0] SGR_FG_HI_FIRST = 16'd91;
  localparam logic [ParamW-1:0] SGR_FG_HI_LAST  = 16'd97;
  localparam logic [ParamW-1:0] SGR_BG_GREY     = 16'd100;
  localparam logic [ParamW-1:0] SGR_BG_HI_FIRST = 16'd101;
  localparam logic [ParamW-1:0] SGR_BG_HI_LAST  = 16'd107;

  localparam logic [ParamW-1:0] SEL_RGB = 16'd2;

  localparam logic [ColourW-1:0] IDX_FAINT    = 9'd250;
  localparam logic [ColourW-1:0] IDX_FG_DEF   = 9'o17;
  localparam logic [ColourW-1:0] IDX_BLACK    = 9'd0;
  localparam logic [ColourW-1:0] IDX_GREY     = 9'o10;
  // 16-colour code minus this offset gives the index (010 + code - base)
  localparam logic [ParamW-1:0] OFS_FG_LO = 16'd22;
  localparam logic [ParamW-1:0] OFS_FG_HI = 16'd82;
  localparam logic [ParamW-1:0] OFS_BG_LO = 16'd32;
  localparam logic [ParamW-1:0] OFS_BG_HI = 16'd92;

  localparam logic [1:0] RGB_LAST = 2'd2;

  typedef struct packed {
    logic [FlagsW-1:0]  flags;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
  } style_t;

  typedef struct packed {
    logic [1:0] pending;
    logic [1:0] idx;
    logic [1:0] rgb;
    logic [1:0] cnt;
  } mode_t;

endpackage

// File: rtl/sgrd_if.sv
// Channel interfaces for the SGR style decoder: parameter in, style out.
// Depends on sgrd_pkg.
interface sgrd_param_if import sgrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ParamW-1:0] param_value;
  logic              first_of_sequence;

  modport source (output valid, param_value, first_of_sequence, input ready);
  modport sink (input valid, param_value, first_of_sequence, output ready);
endinterface

interface sgrd_style_if import sgrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FlagsW-1:0]  style_flags;
  logic [ColourW-1:0] fg_color;
  logic [ColourW-1:0] bg_color;
  logic               colors_reset;

  modport source (output valid, style_flags, fg_color, bg_color, colors_reset,
                  input ready);
  modport sink (input valid, style_flags, fg_color, bg_color, colors_reset,
                output ready);
endinterface

// File: rtl/sgrd_decode.sv
// Next-style logic for one SGR parameter: selectors, colour modes, code table.
// Depends on sgrd_pkg.
module sgrd_decode import sgrd_pkg::*; (
  input  logic [ParamW-1:0] value,
  input  logic              first,
  input  style_t            cur_style,
  input  mode_t             cur_mode,
  output style_t            next_style,
  output mode_t             next_mode,
  output logic              colors_reset
);

  logic [ColourW-1:0] rgb_bits;

  always_comb begin
    case (cur_mode.cnt)
      2'd0:    rgb_bits = {value[7:5], 6'd0};
      2'd1:    rgb_bits = {3'd0, value[7:5], 3'd0};
      default: rgb_bits = {6'd0, value[7:5]};
    endcase
  end

  always_comb begin
    next_style   = cur_style;
    next_mode    = cur_mode;
    colors_reset = 1'b0;
    if (first) begin
      next_mode.pending = 2'b00;
      next_mode.idx     = 2'b00;
      next_mode.rgb     = 2'b00;
    end

    if (next_mode.pending[SIDE_FG]) begin
      next_mode.pending[SIDE_FG] = 1'b0;
      if (value != SEL_RGB) begin
        next_mode.idx[SIDE_FG]         = 1'b1;
        next_style.flags[FL_FG_INDEX] = 1'b1;
      end else begin
        next_mode.rgb[SIDE_FG]       = 1'b1;
        next_style.flags[FL_FG_RGB] = 1'b1;
      end
    end else if (next_mode.pending[SIDE_BG]) begin
      next_mode.pending[SIDE_BG] = 1'b0;
      if (value != SEL_RGB) begin
        next_mode.idx[SIDE_BG]         = 1'b1;
        next_style.flags[FL_BG_INDEX] = 1'b1;
      end else begin
        next_mode.rgb[SIDE_BG]       = 1'b1;
        next_style.flags[FL_BG_RGB] = 1'b1;
      end
    end else if (next_mode.idx[SIDE_FG]) begin
      next_style.fg                 = value[ColourW-1:0];
      next_style.flags[FL_FG_INDEX] = 1'b1;
      next_mode.idx[SIDE_FG]        = 1'b0;
    end else if (next_mode.rgb[SIDE_FG]) begin
      next_style.fg = cur_style.fg | rgb_bits;
      if (cur_mode.cnt >= RGB_LAST) begin
        next_mode.cnt          = 2'd0;
        next_mode.rgb[SIDE_FG] = 1'b0;
      end else begin
        next_mode.cnt = cur_mode.cnt + 2'd1;
      end
    end else if (next_mode.idx[SIDE_BG]) begin
      next_style.bg                 = value[ColourW-1:0];
      next_style.flags[FL_BG_INDEX] = 1'b1;
      next_mode.idx[SIDE_BG]        = 1'b0;
    end else if (next_mode.rgb[SIDE_BG]) begin
      next_style.bg = cur_style.bg | rgb_bits;
      if (cur_mode.cnt >= RGB_LAST) begin
        next_mode.cnt          = 2'd0;
        next_mode.rgb[SIDE_BG] = 1'b0;
      end else begin
        next_mode.cnt = cur_mode.cnt + 2'd1;
      end
    end else begin
      case (value)
        SGR_RESET: begin
          next_style   = '0;
          colors_reset = 1'b1;
        end
        SGR_BOLD, SGR_ALT_FONT: next_style.flags[FL_BOLD] = 1'b1;
        SGR_FAINT: begin
          next_style.fg                 = IDX_FAINT;
          next_style.flags[FL_FG_INDEX] = 1'b1;
        end
        SGR_ITALIC:                     next_style.flags[FL_ITALIC]    = 1'b1;
        SGR_UNDERLINE:                  next_style.flags[FL_UNDERLINE] = 1'b1;
        SGR_BLINK_SLOW, SGR_BLINK_FAST: next_style.flags[FL_BLINK]     = 1'b1;
        SGR_REVERSE:                    next_style.flags[FL_REVERSE]   = 1'b1;
        SGR_INVISIBLE:                  next_style.flags[FL_INVISIBLE] = 1'b1;
        SGR_CROSSED:                    next_style.flags[FL_CROSSED]   = 1'b1;
        SGR_DOUBLE_UL:                  next_style.flags[FL_DOUBLE_UL] = 1'b1;
        SGR_NO_ITALIC:                  next_style.flags[FL_ITALIC]    = 1'b0;
        SGR_NO_UL: begin
          next_style.flags[FL_UNDERLINE] = 1'b0;
          next_style.flags[FL_DOUBLE_UL] = 1'b0;
        end
        SGR_NO_REVERSE: next_style.flags[FL_REVERSE]   = 1'b0;
        SGR_NO_INVIS:   next_style.flags[FL_INVISIBLE] = 1'b0;
        SGR_NO_CROSSED: next_style.flags[FL_CROSSED]   = 1'b0;
        SGR_FG_EXT:     next_mode.pending[SIDE_FG]     = 1'b1;
        SGR_BG_EXT:     next_mode.pending[SIDE_BG]     = 1'b1;
        SGR_FG_DEFAULT, SGR_FG_BLACK, SGR_FG_GREY: begin
          next_style.flags[FL_FG_INDEX] = 1'b1;
          if (value == SGR_FG_DEFAULT) next_style.fg = IDX_FG_DEF;
          else if (value == SGR_FG_GREY) next_style.fg = IDX_GREY;
          else next_style.fg = IDX_BLACK;
        end
        SGR_BG_DEFAULT, SGR_BG_BLACK, SGR_BG_GREY: begin
          next_style.flags[FL_BG_INDEX] = 1'b1;
          next_style.bg = (value == SGR_BG_GREY) ? IDX_GREY : IDX_BLACK;
        end
        default: begin
          if (value >= SGR_FG_LO_FIRST && value <= SGR_FG_LO_LAST) begin
            next_style.fg                 = ColourW'(value - OFS_FG_LO);
            next_style.flags[FL_FG_INDEX] = 1'b1;
          end else if (value >= SGR_FG_HI_FIRST && value <= SGR_FG_HI_LAST) begin
            next_style.fg                 = ColourW'(value - OFS_FG_HI);
            next_style.flags[FL_FG_INDEX] = 1'b1;
          end else if (value >= SGR_BG_LO_FIRST && value <= SGR_BG_LO_LAST) begin
            next_style.bg                 = ColourW'(value - OFS_BG_LO);
            next_style.flags[FL_BG_INDEX] = 1'b1;
          end else if (value >= SGR_BG_HI_FIRST && value <= SGR_BG_HI_LAST) begin
            next_style.bg                 = ColourW'(value - OFS_BG_HI);
            next_style.flags[FL_BG_INDEX] = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/sgr_parameter_style_decoder_core.sv
// Latency: a parameter passes through the input register and then the style register
// before its style transaction. Throughput: one parameter per cycle while style_ch.ready holds.
// Input register, decode, style register.
// The style register is both the rendition state and the output payload.
// Synchronous active-high reset clears style, modes, counter and valid bits.
// Depends on sgrd_pkg, sgrd_if, sgrd_decode and the defines header.
`include "sgr_parameter_style_decoder_core_defines.svh"

module sgr_parameter_style_decoder_core import sgrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sgrd_param_if.sink         param_ch,
  sgrd_style_if.source       style_ch
);

  logic              in_valid;
  logic [ParamW-1:0] in_value;
  logic              in_first;
  logic              out_valid;
  logic              out_reset;
  style_t            style;
  mode_t             mode;
  style_t            style_next;
  mode_t             mode_next;
  logic              reset_next;
  logic              advance;
  logic [5:0]        mode_active;

  assign advance        = in_valid && (!out_valid || style_ch.ready);
  assign param_ch.ready = !in_valid || advance;
  assign mode_active    = {mode.pending, mode.idx, mode.rgb};

  sgrd_decode u_decode (
    .value        (in_value),
    .first        (in_first),
    .cur_style    (style),
    .cur_mode     (mode),
    .next_style   (style_next),
    .next_mode    (mode_next),
    .colors_reset (reset_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (param_ch.ready) begin
      in_valid <= param_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (param_ch.ready && param_ch.valid) begin
      in_value <= param_ch.param_value;
      in_first <= param_ch.first_of_sequence;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_reset <= 1'b0;
      style     <= '0;
      mode      <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      out_reset <= reset_next;
      style     <= style_next;
      mode      <= mode_next;
    end else if (style_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign style_ch.valid        = out_valid;
  assign style_ch.style_flags  = style.flags;
  assign style_ch.fg_color     = style.fg;
  assign style_ch.bg_color     = style.bg;
  assign style_ch.colors_reset = out_reset;

  // at most one of selector / index / rgb is active over both sides
  `SGRD_ASSERT_ALWAYS(a_one_mode, $countones(mode_active) <= 1, "two colour modes active")
  `SGRD_ASSERT_ALWAYS(a_cnt_range, mode.cnt != 2'd3, "rgb component counter out of range")
  `SGRD_ASSERT_IMPLY(a_reset_clear, out_valid && out_reset, style == '0, "reset with style set")
  `SGRD_ASSERT_IMPLY(a_hold_full, in_valid && !advance, !param_ch.ready, "input taken while full")

endmodule
